// ===== design/pan_tilt_pointing_angles_assert.svh =====
// Assertion helpers used by the checker file
`ifndef PAN_TILT_POINTING_ANGLES_ASSERT_SVH
`define PAN_TILT_POINTING_ANGLES_ASSERT_SVH

// same-cycle implication, off while reset is held
`define PTPA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is held
`define PTPA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== design/ptpa_pkg.sv =====
`timescale 1ns / 1ps
package ptpa_pkg;
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 32;
    localparam int FIELD_W     = 16;
    localparam int PAN_W       = 14;
    localparam int TILT_W      = 15;

    // angle accumulator in 2^-16 degree
    localparam int ZW         = 26;
    localparam int FRAC_SHIFT = 10;
    localparam int AW         = ZW - FRAC_SHIFT;
    localparam int FW         = 18;
    localparam int TABLE_LEN  = 24;

    localparam logic signed [ZW-1:0] MICRO_ANGLE [TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
        26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115,
        26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
    };
    localparam logic signed [ZW-1:0] QUARTER_FINE = 26'sd5898240;
    localparam logic signed [ZW-1:0] ROUND_HALF   = 26'sd512;
    localparam logic signed [FW-1:0] HALF_TURN    = 18'sd11520;
    localparam logic signed [FW-1:0] QUARTER_TURN = 18'sd5760;
endpackage

// ===== design/ptpa_sqrt_cell.sv =====
`timescale 1ns / 1ps
// one result bit of the integer square root, remainder form
module ptpa_sqrt_cell #(
    parameter int W = 16,
    parameter int K = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [2*W:0]   rem_in,
    input  logic [W-1:0]   root_in,
    output logic [2*W:0]   rem_out,
    output logic [W-1:0]   root_out
);
    logic [2*W:0] trial;
    logic [2*W:0] rem_reg;
    logic [W-1:0] root_reg;

    // (r + 2^K)^2 - r^2
    assign trial = ({{(W+1){1'b0}}, root_in} << (K + 1)) + ((2*W+1)'(1) << (2 * K));

    always_ff @(posedge aclk) begin
        if (en) begin
            if (rem_in >= trial) begin
                rem_reg  <= rem_in - trial;
                root_reg <= root_in | (W'(1) << K);
            end else begin
                rem_reg  <= rem_in;
                root_reg <= root_in;
            end
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// ===== design/ptpa_cordic_cell.sv =====
`timescale 1ns / 1ps
module ptpa_cordic_cell import ptpa_pkg::*; #(
    parameter int XW = 19,
    parameter int I  = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    assign dx = y_in >>> I;
    assign dy = x_in >>> I;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!y_in[XW-1]) begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + MICRO_ANGLE[I];
            end else begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - MICRO_ANGLE[I];
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// ===== design/ptpa_cordic.sv =====
`timescale 1ns / 1ps
// atan2(y, x): quarter-turn pre-rotation register, then a row of vectoring cells
module ptpa_cordic import ptpa_pkg::*; #(
    parameter int W      = 16,
    parameter int STAGES = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [W:0]    y_in,
    input  logic signed [W:0]    x_in,
    output logic signed [ZW-1:0] z_out,
    output logic                 zero_out
);
    localparam int XW = W + 3;

    logic signed [XW-1:0] xe, ye, x0, y0;
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] xs [STAGES+1];
    logic signed [XW-1:0] ys [STAGES+1];
    logic signed [ZW-1:0] zs [STAGES+1];
    logic                 zero_reg [STAGES+1];
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    assign xe = {{2{x_in[W]}}, x_in};
    assign ye = {{2{y_in[W]}}, y_in};

    always_comb begin
        x0 = xe;
        y0 = ye;
        z0 = '0;
        if (x_in[W]) begin
            if (!y_in[W]) begin
                x0 = ye;
                y0 = -xe;
                z0 = QUARTER_FINE;
            end else begin
                x0 = -ye;
                y0 = xe;
                z0 = -QUARTER_FINE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg       <= x0;
            y_reg       <= y0;
            z_reg       <= z0;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            for (int i = 0; i < STAGES; i++) begin
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign xs[0] = x_reg;
    assign ys[0] = y_reg;
    assign zs[0] = z_reg;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        ptpa_cordic_cell #(.XW(XW), .I(g)) u_cell (
            .aclk (aclk),
            .en   (en),
            .x_in (xs[g]),
            .y_in (ys[g]),
            .z_in (zs[g]),
            .x_out(xs[g+1]),
            .y_out(ys[g+1]),
            .z_out(zs[g+1])
        );
    end

    assign z_out    = zs[STAGES];
    assign zero_out = zero_reg[STAGES];
endmodule

// ===== design/pan_tilt_pointing_angles.sv =====
`timescale 1ns / 1ps
// Pan/tilt pointing angles for a two-axis mount.
// Input word (s_): mount matrix, nine Q2.14 elements, and a unit target
// direction, three Q2.14 elements. The target is rotated into the mount frame,
// then pan and tilt come from two CORDIC vectoring rows running side by side.
// Output word (m_): pan in 1/64 degree folded to +-90, tilt in 1/64 degree.
// Pipeline registers, in order: products, sums, scaling, squares, radius sum,
// one square-root cell per radius bit, pre-rotation, one CORDIC cell per stage,
// fold and output register.
// Throughput: one word per cycle unless the receiver stalls; every stage is a
// register in one pipeline. When the receiver stalls with a word held in the
// output register, the whole pipeline holds and s_tready drops; it rises again
// in the cycle m_tready does. Reset clears the valid line and the output valid;
// data registers keep junk that is never shown.
module pan_tilt_pointing_angles import ptpa_pkg::*; #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // r00 r10 r20 r01 r11 r21 r02 r12 r22 target_x target_y target_z, 16 each
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pan_angle [13:0], tilt_angle [28:14], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);
    localparam int W   = COORD_WIDTH;
    localparam int S   = CORDIC_STAGES;
    localparam int NSH = 33 - W;
    localparam int D   = W + 2;
    localparam int DL  = W + S + 3;
    localparam int L   = W + S + 6;

    logic                      en;
    logic signed [FIELD_W-1:0] fld [12];
    logic signed [31:0]        prod_reg [9];
    logic signed [33:0]        loc_reg [3];
    logic [33:0]               mag [3];
    logic [W-1:0]              mshift [3];
    logic signed [W-1:0]       pv [3];
    logic signed [W-1:0]       px_reg, py_reg, pz_reg;
    logic                      lzneg_reg;
    logic [W-1:0]              ux, uy;
    logic [2*W-1:0]            sqx_reg, sqy_reg;
    logic [2*W:0]              n_reg;
    logic [2*W:0]              rems [W+1];
    logic [W-1:0]              roots [W+1];
    logic signed [W-1:0]       dpx_reg [D];
    logic signed [W-1:0]       dpy_reg [D];
    logic signed [W-1:0]       dpz_reg [D];
    logic                      dlz_reg [DL];
    logic                      valid_reg [L];
    logic signed [W:0]         pan_y, pan_x, tilt_y, tilt_x;
    logic signed [ZW-1:0]      pan_z, tilt_z;
    logic                      pan_zero, tilt_zero;
    logic signed [ZW-1:0]      pan_rz, tilt_rz;
    logic signed [FW-1:0]      pan_f, tilt_f;
    logic m_tvalid_reg;
    logic [PAN_W-1:0]          pan_reg;
    logic [TILT_W-1:0]         tilt_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            fld[k] = s_tdata[FIELD_W*k +: FIELD_W];
        end
        for (int i = 0; i < 3; i++) begin
            mag[i]    = loc_reg[i][33] ? 34'(-loc_reg[i]) : loc_reg[i];
            mshift[i] = mag[i][NSH +: W];
            pv[i]     = loc_reg[i][33] ? -$signed(mshift[i]) : $signed(mshift[i]);
        end
        ux = px_reg[W-1] ? W'(-px_reg) : W'(px_reg);
        uy = py_reg[W-1] ? W'(-py_reg) : W'(py_reg);
    end

    // mount-frame target, scaling, squares and radius sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[i*3+k] <= fld[i*3+k] * fld[9+k];
                end
                loc_reg[i] <= {{2{prod_reg[i*3][31]}}, prod_reg[i*3]}
                            + {{2{prod_reg[i*3+1][31]}}, prod_reg[i*3+1]}
                            + {{2{prod_reg[i*3+2][31]}}, prod_reg[i*3+2]};
            end
            px_reg    <= pv[0];
            py_reg    <= pv[1];
            pz_reg    <= pv[2];
            lzneg_reg <= loc_reg[2][33];
            sqx_reg   <= ux * ux;
            sqy_reg   <= uy * uy;
            n_reg     <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            dpx_reg[0] <= px_reg;
            dpy_reg[0] <= py_reg;
            dpz_reg[0] <= pz_reg;
            dlz_reg[0] <= lzneg_reg;
            for (int j = 1; j < D; j++) begin
                dpx_reg[j] <= dpx_reg[j-1];
                dpy_reg[j] <= dpy_reg[j-1];
                dpz_reg[j] <= dpz_reg[j-1];
            end
            for (int j = 1; j < DL; j++) begin
                dlz_reg[j] <= dlz_reg[j-1];
            end
        end
    end

    assign rems[0]  = n_reg;
    assign roots[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_sqrt
        ptpa_sqrt_cell #(.W(W), .K(W - 1 - g)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .rem_in  (rems[g]),
            .root_in (roots[g]),
            .rem_out (rems[g+1]),
            .root_out(roots[g+1])
        );
    end

    assign pan_y  = -{dpx_reg[D-1][W-1], dpx_reg[D-1]};
    assign pan_x  = {dpy_reg[D-1][W-1], dpy_reg[D-1]};
    assign tilt_y = -{dpz_reg[D-1][W-1], dpz_reg[D-1]};
    assign tilt_x = {1'b0, roots[W]};

    ptpa_cordic #(.W(W), .STAGES(S)) u_pan (
        .aclk    (aclk),
        .en      (en),
        .y_in    (pan_y),
        .x_in    (pan_x),
        .z_out   (pan_z),
        .zero_out(pan_zero)
    );

    ptpa_cordic #(.W(W), .STAGES(S)) u_tilt (
        .aclk    (aclk),
        .en      (en),
        .y_in    (tilt_y),
        .x_in    (tilt_x),
        .z_out   (tilt_z),
        .zero_out(tilt_zero)
    );

    // round to 1/64 degree, fold pan into +-90, adjust tilt
    always_comb begin
        pan_rz  = pan_zero  ? '0 : ((pan_z + ROUND_HALF) >>> FRAC_SHIFT);
        tilt_rz = tilt_zero ? '0 : ((tilt_z + ROUND_HALF) >>> FRAC_SHIFT);
        pan_f   = FW'(pan_rz[AW-1:0]);
        tilt_f  = FW'(tilt_rz[AW-1:0]);
        pan_f   = {{(FW-AW){pan_rz[AW-1]}}, pan_rz[AW-1:0]};
        tilt_f  = {{(FW-AW){tilt_rz[AW-1]}}, tilt_rz[AW-1:0]};
        if (pan_f > QUARTER_TURN) begin
            pan_f = pan_f - HALF_TURN;
        end else if (pan_f < -QUARTER_TURN) begin
            pan_f = pan_f + HALF_TURN;
        end else begin
            tilt_f = -tilt_f;
        end
        if (tilt_f < 0) begin
            tilt_f = tilt_f + HALF_TURN;
        end
        if (dlz_reg[DL-1]) begin
            tilt_f = tilt_f + HALF_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            for (int j = 0; j < L; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            m_tvalid_reg <= valid_reg[L-1];
            valid_reg[0] <= s_tvalid;
            for (int j = 1; j < L; j++) begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pan_reg  <= pan_f[PAN_W-1:0];
            tilt_reg <= tilt_f[TILT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-PAN_W-TILT_W){1'b0}}, tilt_reg, pan_reg};
endmodule

// ===== design/ptpa_checker.sv =====
`timescale 1ns / 1ps
`include "pan_tilt_pointing_angles_assert.svh"
module ptpa_checker import ptpa_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);
    `PTPA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PTPA_ASSERT_IMPL(a_ready, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))
    `PTPA_ASSERT_IMPL(a_pan, aclk, aresetn, m_tvalid, ($signed(m_tdata[13:0]) >= -14'sd5760) && ($signed(m_tdata[13:0]) <= 14'sd5760))
    `PTPA_ASSERT_IMPL(a_tilt, aclk, aresetn, m_tvalid, (m_tdata[28:14] <= 15'd23040) && (m_tdata[31:29] == 3'd0))
endmodule

bind pan_tilt_pointing_angles ptpa_checker u_ptpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
